>>> src/fit_policy_block_allocator_unit_assert.svh
// Assertion macros for the block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define FPBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define FPBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fpba_pkg.sv
`default_nettype none

package fpba_pkg;

  typedef logic [1:0] fit_mode_t;
  typedef logic [4:0] block_count_t;
  typedef logic       cfg_index_t;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam fit_mode_t MODE_FIRST = 2'd0;
  localparam fit_mode_t MODE_BEST  = 2'd1;
  localparam fit_mode_t MODE_WORST = 2'd2;

  localparam cfg_index_t CFG_FIT_MODE    = 1'b0;
  localparam cfg_index_t CFG_BLOCK_COUNT = 1'b1;

  localparam int CFG_DATA_W = 5;

  localparam fit_mode_t    FIT_MODE_RST    = MODE_FIRST;
  localparam block_count_t BLOCK_COUNT_RST = 5'd16;

endpackage

`default_nettype wire

>>> src/fit_policy_block_allocator_unit.sv
// Block allocator with first, best and worst fit. A load transaction writes one
// free size into the table (ignored when the index is at or above NUM_BLOCKS). A
// request transaction reads the first min(block_count, NUM_BLOCKS) table entries,
// one per cycle through the single read port of the table memory, keeps the chosen
// entry, then writes its reduced size back if an entry fit and issues one result;
// no new transaction is taken until the request has finished its scan and passed
// its result to the output register, which waits longer while an earlier result
// still sits there. The result sits in an output register, so the next
// transaction can be taken while it waits. Entries never loaded read as undefined.
// Configuration is to be written only while idle; the block does not enforce this.
`default_nettype none

module fit_policy_block_allocator_unit #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire fpba_pkg::cfg_index_t         cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [3:0]                   load_index,
  input  wire logic [15:0]                  size_value,
  input  wire logic                         final_request,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              found,
  output logic [3:0]                        granted_index,
  output logic [15:0]                       left_over,
  output logic                              final_result
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]                 state;
  fpba_pkg::fit_mode_t        fit_mode;
  fpba_pkg::block_count_t     block_count;

  logic [SIZE_BITS-1:0]       mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]       rd_data;
  logic                       rd_pend;
  logic [IDX_W-1:0]           rd_idx;
  logic [CNT_W-1:0]           issue_cnt;
  logic [CNT_W-1:0]           limit;
  logic [SIZE_BITS-1:0]       req_size;
  logic                       req_fin;
  logic                       have;
  logic [IDX_W-1:0]           pick;
  logic [SIZE_BITS-1:0]       pick_size;

  logic                       in_fire;
  logic                       load_ok;
  logic [CNT_W-1:0]           sat_count;
  logic                       fits;
  logic                       take;
  logic                       out_free;
  logic                       write_fire;
  logic [SIZE_BITS-1:0]       left_next;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [SIZE_BITS-1:0]       mem_wdata;

  assign in_stall   = (state != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign load_ok    = 32'(load_index) < NUM_BLOCKS;
  assign sat_count  = (32'(block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(block_count);
  assign fits       = rd_data >= req_size;
  assign take       = (state == ST_SCAN) && rd_pend && fits &&
                      (!have ||
                       ((fit_mode == fpba_pkg::MODE_BEST)  && (rd_data < pick_size)) ||
                       ((fit_mode == fpba_pkg::MODE_WORST) && (rd_data > pick_size)));
  assign out_free   = !out_valid || !out_stall;
  assign write_fire = (state == ST_WRITE) && out_free;
  assign left_next  = pick_size - req_size;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick;
    mem_wdata = left_next;
    if (write_fire && have) begin
      mem_we = 1'b1;
    end else if (in_fire && (action == fpba_pkg::ACT_LOAD) && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(load_index);
      mem_wdata = SIZE_BITS'(size_value);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[issue_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      fit_mode    <= fpba_pkg::FIT_MODE_RST;
      block_count <= fpba_pkg::BLOCK_COUNT_RST;
      have        <= 1'b0;
      rd_pend     <= 1'b0;
      issue_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fpba_pkg::CFG_FIT_MODE:    fit_mode    <= cfg_data[1:0];
          fpba_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          issue_cnt <= '0;
          rd_pend   <= 1'b0;
          have      <= 1'b0;
          if (in_fire && (action == fpba_pkg::ACT_REQUEST)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend <= issue_cnt < limit;
          if (issue_cnt < limit) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (take) begin
            have <= 1'b1;
          end
          if ((issue_cnt == limit) && !rd_pend) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (action == fpba_pkg::ACT_REQUEST)) begin
      req_size <= SIZE_BITS'(size_value);
      req_fin  <= final_request;
      limit    <= sat_count;
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (take) begin
      pick      <= rd_idx;
      pick_size <= rd_data;
    end
    if (write_fire) begin
      found         <= have;
      granted_index <= have ? 4'(pick) : 4'd0;
      left_over     <= have ? 16'(left_next) : 16'd0;
      final_result  <= req_fin;
    end
  end

`include "fit_policy_block_allocator_unit_assert.svh"

  `FPBA_ASSERT_NOW(a_scan_bound, state == ST_SCAN, issue_cnt <= limit, "scan ran past limit")
  `FPBA_ASSERT_NOW(a_pick_fits, (state == ST_SCAN) && have, pick_size >= req_size, "pick too small")
  `FPBA_ASSERT_NOW(a_pick_range, (state == ST_WRITE) && have, 32'(pick) < 32'(limit), "pick out of range")
  `FPBA_ASSERT_NEXT(a_req_scan, in_fire && (action == fpba_pkg::ACT_REQUEST), state == ST_SCAN, "request did not start scan")
  `FPBA_ASSERT_NEXT(a_out_drain, out_valid && !out_stall && (state != ST_WRITE), !out_valid, "result repeated")

endmodule

`default_nettype wire
